// ===== rtl/itrd_pkg.sv =====
// Shared types and constants for the image-disk track record decoder.
// No dependencies.
`default_nettype none
package itrd_pkg;
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRACK_END = 2'd1;
    localparam logic [1:0] KIND_WARN = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_GEOMETRY = 3'd1;
    localparam logic [2:0] ST_TYPE = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_NO_TERM = 3'd4;
    localparam logic [2:0] ST_TRUNC = 3'd5;

    localparam logic [7:0] HDR_TERM = 8'h1a;
    localparam logic [7:0] FLAG_CMAP = 8'h80;
    localparam logic [7:0] FLAG_HMAP = 8'h40;
    localparam logic [7:0] SIZE_MASK = 8'h03;
    localparam logic [10:0] BASE_SECTOR = 11'd128;

    // One result item; status fields come from the front at issue time.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  fill;
        logic [10:0] run;
        logic [2:0]  status;
        logic [7:0]  track;
        logic [8:0]  tracks;
        logic [1:0]  sides;
        logic [5:0]  spt;
        logic [10:0] sbytes;
        logic        dens;
        logic [8:0]  skew;
    } res_t;

    // Work handed from the parser to the address stage.
    typedef struct packed {
        logic        is_write;   // compute an address from sector and offset
        logic [7:0]  sec;
        logic [10:0] offset;
        res_t        res;
    } job_t;

    function automatic logic [10:0] size_bytes(input logic [1:0] code);
        size_bytes = BASE_SECTOR << code;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/itrd_front.sv =====
// Byte parser: header skip, track record fields, geometry learning, sector map.
// Depends on itrd_pkg. Issues one job per byte that yields a result.
`default_nettype none
module itrd_front #(
    parameter int MAX_SECTORS = 32,
    parameter int ADDR_BITS = 23
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_byte,
    input  wire logic               file_start,
    input  wire logic               final_byte,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output itrd_pkg::job_t          job,
    output logic [ADDR_BITS-1:0]    base
);
    localparam int SW = $clog2(MAX_SECTORS + 1);
    localparam int IW = $clog2(MAX_SECTORS);

    typedef enum logic [3:0] {
        PH_HDR, PH_MODE, PH_CYL, PH_HEAD, PH_SPT, PH_SIZE, PH_SMAP,
        PH_CMAP, PH_HMAP, PH_TYPE, PH_DATA, PH_FILL
    } phase_t;

    phase_t          phase_reg, ph;
    logic [10:0]     bc_reg, bc;
    logic [SW-1:0]   si_reg, si;
    logic [7:0]      smap_reg [MAX_SECTORS];
    logic            known_reg, known;
    logic [SW-1:0]   spt_reg, spt;
    logic [1:0]      code_reg, code;
    logic            dens_reg, dens;
    logic [8:0]      skew_reg, skew;
    logic [8:0]      tc_reg, tc;
    logic [1:0]      sc_reg, sc;
    logic [ADDR_BITS-1:0] base_reg, base_n;
    logic [7:0]      cyl_reg, cyl;
    logic            fcm_reg, fcm, fhm_reg, fhm, flearn_reg, flearn, fdens_reg, fdens;
    logic            err_reg, err_n;
    logic            wr_map;
    logic [2:0]      err;
    logic            emit;
    itrd_pkg::job_t  j;
    logic [10:0]     ssz;
    logic [7:0]      sec;
    logic            fin, endtr;
    logic [SW-1:0]   si1;
    logic [31:0]     adv;

    assign in_ready = job_ready;
    assign base = base_reg;
    assign ssz = itrd_pkg::size_bytes(code_reg);
    assign sec = (si_reg < SW'(MAX_SECTORS)) ? smap_reg[si_reg[IW-1:0]] : 8'd0;
    assign si1 = si_reg + SW'(1);
    assign adv = 32'(spt_reg) * 32'(ssz);

    // Next-state parse logic, following the file format phase by phase
    always_comb begin
        logic fs;
        logic [8:0] tc0;
        fs = file_start;
        tc0 = fs ? 9'd0 : tc_reg;
        ph = fs ? PH_HDR : phase_reg;
        bc = fs ? 11'd0 : bc_reg;
        si = fs ? '0 : si_reg;
        known = fs ? 1'b0 : known_reg;
        spt = fs ? '0 : spt_reg;
        code = fs ? 2'd0 : code_reg;
        dens = fs ? 1'b0 : dens_reg;
        skew = fs ? 9'd0 : skew_reg;
        tc = tc0;
        sc = fs ? 2'd0 : sc_reg;
        base_n = fs ? '0 : base_reg;
        cyl = fs ? 8'd0 : cyl_reg;
        fcm = fs ? 1'b0 : fcm_reg;
        fhm = fs ? 1'b0 : fhm_reg;
        flearn = fs ? 1'b0 : flearn_reg;
        fdens = fs ? 1'b0 : fdens_reg;
        err_n = fs ? 1'b0 : err_reg;
        err = itrd_pkg::ST_OK;
        emit = 1'b0;
        wr_map = 1'b0;
        fin = 1'b0;
        endtr = 1'b0;
        j = '0;
        j.res.kind = itrd_pkg::KIND_WRITE;
        if (!err_n) begin
            // sector completion shared by type 0, data end and fill
            unique case (ph)
                PH_HDR: if (in_byte == itrd_pkg::HDR_TERM) ph = PH_MODE;
                PH_MODE: begin
                    fdens = (in_byte >= 8'd3);
                    fcm = 1'b0; fhm = 1'b0; flearn = 1'b0;
                    cyl = 8'd0;
                    ph = PH_CYL;
                end
                PH_CYL: begin
                    cyl = in_byte;
                    if (tc != 9'd0 && {1'b0, in_byte} != tc) begin
                        emit = 1'b1;
                        j.res.kind = itrd_pkg::KIND_WARN;
                    end
                    if ({1'b0, in_byte} >= tc) tc = {1'b0, in_byte} + 9'd1;
                    ph = PH_HEAD;
                end
                PH_HEAD: begin
                    if ((in_byte & itrd_pkg::FLAG_CMAP) != 8'd0) fcm = 1'b1;
                    if ((in_byte & itrd_pkg::FLAG_HMAP) != 8'd0) fhm = 1'b1;
                    if ({1'b0, in_byte[0]} >= sc) sc = {1'b0, in_byte[0]} + 2'd1;
                    ph = PH_SPT;
                end
                PH_SPT: begin
                    if (in_byte == 8'd0 || 32'(in_byte) > 32'(MAX_SECTORS))
                        err = itrd_pkg::ST_RANGE;
                    else begin
                        bc = {3'd0, in_byte};
                        ph = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    if (known) begin
                        if (bc != 11'(spt) || (in_byte[1:0]) != code || fdens != dens)
                            err = itrd_pkg::ST_GEOMETRY;
                        else flearn = 1'b0;
                    end else begin
                        spt = SW'(bc);
                        code = in_byte[1:0];
                        dens = fdens;
                        skew = 9'd0;
                        known = 1'b1;
                        flearn = 1'b1;
                    end
                    if (err == itrd_pkg::ST_OK) begin
                        bc = 11'd0;
                        si = '0;
                        ph = PH_SMAP;
                    end
                end
                PH_SMAP: begin
                    if (flearn && 32'(bc) < 32'(MAX_SECTORS)) begin
                        wr_map = 1'b1;
                        if (bc == 11'd1) skew = {1'b0, in_byte} - {1'b0, smap_reg[0]};
                    end
                    bc = bc + 11'd1;
                    if (bc >= 11'(spt)) begin
                        bc = 11'd0;
                        ph = fcm ? PH_CMAP : (fhm ? PH_HMAP : PH_TYPE);
                    end
                end
                PH_CMAP: begin
                    bc = bc + 11'd1;
                    if (bc >= 11'(spt)) begin
                        bc = 11'd0;
                        ph = fhm ? PH_HMAP : PH_TYPE;
                    end
                end
                PH_HMAP: begin
                    bc = bc + 11'd1;
                    if (bc >= 11'(spt)) begin
                        bc = 11'd0;
                        ph = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (in_byte == 8'd0) begin
                        fin = 1'b1;
                    end else if (in_byte == 8'd1 || in_byte == 8'd2) begin
                        if (sec == 8'd0 || 32'(sec) > 32'(spt))
                            err = itrd_pkg::ST_RANGE;
                        else begin
                            bc = 11'd0;
                            ph = (in_byte == 8'd1) ? PH_DATA : PH_FILL;
                        end
                    end else err = itrd_pkg::ST_TYPE;
                end
                PH_DATA: begin
                    emit = 1'b1;
                    j.is_write = 1'b1;
                    j.sec = sec;
                    j.offset = bc;
                    j.res.fill = in_byte;
                    j.res.run = 11'd1;
                    bc = bc + 11'd1;
                    if (bc >= ssz) fin = 1'b1;
                end
                PH_FILL: begin
                    emit = 1'b1;
                    j.is_write = 1'b1;
                    j.sec = sec;
                    j.res.fill = in_byte;
                    j.res.run = ssz;
                    fin = 1'b1;
                end
                default: ph = PH_HDR;
            endcase
            if (fin) begin
                si = si1;
                bc = 11'd0;
                if (si1 >= spt) begin
                    endtr = 1'b1;
                    base_n = base_reg + ADDR_BITS'(adv);
                    ph = PH_MODE;
                end else ph = PH_TYPE;
                if (endtr) begin
                    emit = 1'b1;
                    j.res.kind = itrd_pkg::KIND_TRACK_END;
                end
            end
            if (err == itrd_pkg::ST_OK && final_byte) begin
                if (ph == PH_HDR) err = itrd_pkg::ST_NO_TERM;
                else if (ph != PH_MODE) err = itrd_pkg::ST_TRUNC;
            end
            if (err != itrd_pkg::ST_OK) begin
                err_n = 1'b1;
                emit = 1'b1;
                j = '0;
                j.res.kind = itrd_pkg::KIND_ERROR;
                j.res.status = err;
            end
        end
        // status snapshot after this byte's updates; base rides in addr
        j.res.addr = 32'(base_reg);
        j.res.track = cyl;
        // a warning reports the track count from before its cylinder byte
        j.res.tracks = (j.res.kind == itrd_pkg::KIND_WARN) ? tc0 : tc;
        j.res.sides = sc;
        j.res.spt = 6'(spt);
        j.res.sbytes = known ? itrd_pkg::size_bytes(code) : 11'd0;
        j.res.dens = dens;
        j.res.skew = skew;
    end

    // Parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            bc_reg <= '0; si_reg <= '0; known_reg <= 1'b0; spt_reg <= '0;
            code_reg <= '0; dens_reg <= 1'b0; skew_reg <= '0; tc_reg <= '0;
            sc_reg <= '0; base_reg <= '0; cyl_reg <= '0; fcm_reg <= 1'b0;
            fhm_reg <= 1'b0; flearn_reg <= 1'b0; fdens_reg <= 1'b0;
            err_reg <= 1'b0; job_valid <= 1'b0;
        end else if (in_valid && in_ready) begin
            phase_reg <= ph;
            bc_reg <= bc; si_reg <= si; known_reg <= known; spt_reg <= spt;
            code_reg <= code; dens_reg <= dens; skew_reg <= skew; tc_reg <= tc;
            sc_reg <= sc; base_reg <= base_n; cyl_reg <= cyl; fcm_reg <= fcm;
            fhm_reg <= fhm; flearn_reg <= flearn; fdens_reg <= fdens;
            err_reg <= err_n; job_valid <= emit;
        end else if (job_ready) begin
            job_valid <= 1'b0;
        end
    end

    // Job payload and sector map
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            job <= j;
            if (wr_map) smap_reg[bc_reg[IW-1:0]] <= in_byte;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/itrd_back.sv =====
// Address stage: multiplies sector by size and adds the track base.
// Depends on itrd_pkg. Holds a two-entry queue ahead of the output register.
`default_nettype none
module itrd_back #(
    parameter int ADDR_BITS = 23
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            job_valid,
    output logic                 job_ready,
    input  wire itrd_pkg::job_t  job,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output itrd_pkg::res_t       res
);
    itrd_pkg::job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    logic       push, pop;
    itrd_pkg::job_t h;
    itrd_pkg::res_t res_next;
    logic [31:0] a;

    assign h = q_reg[rd_reg];
    assign pop = (cnt_reg != 2'd0) && (!out_valid || out_ready);
    assign job_ready = (cnt_reg != 2'd2) || pop;
    assign push = job_valid && job_ready;
    // address: base (carried in addr) + (sector-1)*size + offset
    assign a = h.res.addr + 32'(h.sec - 8'd1) * 32'(h.res.sbytes) + 32'(h.offset);

    // Result payload with the computed address; non-writes carry zero
    always_comb begin
        res_next = h.res;
        res_next.addr = h.is_write ? 32'(a[ADDR_BITS-1:0]) : 32'd0;
    end

    // Queue control and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; rd_reg <= 1'b0; wr_reg <= 1'b0; out_valid <= 1'b0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            if (pop) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
        end
    end

    // Queue storage and result payload
    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= job;
        if (pop) res <= res_next;
    end
endmodule
`default_nettype wire

// ===== rtl/imd_track_record_decoder.sv =====
// Top level of the image-disk track record decoder.
// Depends on itrd_pkg, itrd_front and itrd_back.
// Takes one file byte per clock while results can move on and gives at most one
// result item per byte, in order. The parser handles a byte each cycle unless held;
// results pass its job register, a two-entry queue and an address stage (one
// multiply-add); the sector map is learned from the first track; no clearing pass.
`default_nettype none
module imd_track_record_decoder #(
    parameter int MAX_SECTORS = 32,
    parameter int ADDR_BITS = 23
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tlast,   // final_byte
    input  wire logic        s_tuser,   // file_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata from bit 0: image_address(ADDR_BITS), fill_value(8), run_length(11),
    // status_code(3), track_number(8), tracks_seen(9), sides_seen(2),
    // sectors_per_track(6), sector_bytes(11), double_density(1), sector_skew(9)
    output logic [((ADDR_BITS + 68 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]       m_tuser    // out_kind
);
    localparam int DW = ((ADDR_BITS + 68 + 7) / 8) * 8;
    logic jv, jr;
    itrd_pkg::job_t jb;
    itrd_pkg::res_t r;
    logic [ADDR_BITS-1:0] base;

    itrd_front #(.MAX_SECTORS(MAX_SECTORS), .ADDR_BITS(ADDR_BITS)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .file_start(s_tuser), .final_byte(s_tlast),
        .job_valid(jv), .job_ready(jr), .job(jb), .base(base)
    );

    itrd_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .aclk, .aresetn, .job_valid(jv), .job_ready(jr), .job(jb),
        .out_valid(m_tvalid), .out_ready(m_tready), .res(r)
    );

    assign m_tuser = r.kind;
    assign m_tdata = DW'({r.skew, r.dens, r.sbytes, r.spt, r.sides, r.tracks,
                          r.track, r.status, r.run, r.fill, r.addr[ADDR_BITS-1:0]});

    // Error items carry no write.
    a_err_norun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == itrd_pkg::KIND_ERROR |-> r.run == 11'd0)
        else $error("error item with nonzero run");
    // A held result stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    // The track base only moves on an accepted byte.
    a_base: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) |=> $stable(base))
        else $error("track base changed without input");
endmodule
`default_nettype wire

// ===== verif/imd_track_record_decoder_test.sv =====
// Self-checking testbench for the image-disk track record decoder.
// Depends on itrd_pkg and imd_track_record_decoder; runs standalone.
// Image files are built byte by byte and predicted here; each result item is checked in order.
`default_nettype none
module imd_track_record_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEC = 32;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [3:0] {
        P_HDR, P_MODE, P_CYL, P_HEAD, P_SPT, P_SIZE, P_SMAP,
        P_CMAP, P_HMAP, P_TYPE, P_DATA, P_FILL
    } phase_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [22:0] addr;
        logic [7:0]  fill;
        logic [10:0] run;
        logic [2:0]  status;
        logic [7:0]  track;
        logic [8:0]  tracks;
        logic [1:0]  sides;
        logic [5:0]  spt;
        logic [10:0] sbytes;
        logic        dens;
        logic [8:0]  skew;
    } rec_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    imd_track_record_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Parser shadow state
    phase_e      ph;
    logic [10:0] bcount;
    logic [5:0]  sidx;
    logic [7:0]  smap [MAX_SEC];
    logic        known;
    logic [5:0]  lspt;
    logic [1:0]  lcode;
    logic        ldens;
    logic [8:0]  lskew;
    logic [8:0]  tcount;
    logic [1:0]  scount;
    logic [22:0] tbase;
    logic [7:0]  cur_cyl;
    logic        f_cmap, f_hmap, f_learn, f_dens;
    logic        sticky;

    rec_result_t expected_q [$];
    byte unsigned file_q [$];
    int  send_idle, recv_idle, hold_cycles;
    int  mismatches, cycles, items_sent;

    // Clock, cycle limit
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void clear_parser();
        ph = P_HDR; bcount = '0; sidx = '0; known = 0; lspt = '0; lcode = '0;
        ldens = 0; lskew = '0; tcount = '0; scount = '0; tbase = '0; cur_cyl = '0;
        f_cmap = 0; f_hmap = 0; f_learn = 0; f_dens = 0; sticky = 0;
        for (int i = 0; i < MAX_SEC; i++) smap[i] = '0;
    endfunction

    function automatic rec_result_t make_result(logic [1:0] kind, logic [22:0] addr,
            logic [7:0] fill, logic [10:0] run, logic [2:0] status);
        rec_result_t r;
        r.kind = kind; r.addr = addr; r.fill = fill; r.run = run; r.status = status;
        r.track = cur_cyl; r.tracks = tcount; r.sides = scount; r.spt = lspt;
        r.sbytes = known ? (11'd128 << lcode) : 11'd0;
        r.dens = ldens; r.skew = lskew;
        return r;
    endfunction

    // Advance to the next sector; 1 when the track is complete
    function automatic bit next_sector();
        logic [31:0] step;
        sidx = sidx + 6'd1;
        bcount = '0;
        if (sidx >= lspt) begin
            step = 32'(lspt) * (32'd128 << lcode);
            tbase = 23'(32'(tbase) + step);
            ph = P_MODE;
            return 1;
        end
        ph = P_TYPE;
        return 0;
    endfunction

    // Predicts the effect of one byte; returns 1 when it yields a result item
    function automatic bit decode_byte(logic [7:0] b, bit start, bit last,
            output rec_result_t r);
        logic [10:0] ssz;
        logic [7:0]  sec;
        logic [2:0]  err;
        logic [31:0] a;
        bit got, fin;
        got = 0; err = itrd_pkg::ST_OK; r = '0;
        if (start) clear_parser();
        if (sticky) return 0;
        ssz = 11'd128 << lcode;
        sec = (sidx < MAX_SEC) ? smap[sidx] : 8'd0;
        case (ph) inside
            P_HDR: if (b == itrd_pkg::HDR_TERM) ph = P_MODE;
            P_MODE: begin
                f_dens = (b >= 8'd3); f_cmap = 0; f_hmap = 0; f_learn = 0;
                cur_cyl = '0;
                ph = P_CYL;
            end
            P_CYL: begin
                cur_cyl = b;
                if (tcount != 0 && 9'(b) != tcount) begin
                    r = make_result(itrd_pkg::KIND_WARN, '0, '0, '0, itrd_pkg::ST_OK);
                    got = 1;
                end
                if (9'(b) >= tcount) tcount = 9'(b) + 9'd1;
                ph = P_HEAD;
            end
            P_HEAD: begin
                if (b[7]) f_cmap = 1;
                if (b[6]) f_hmap = 1;
                if (2'(b[0]) >= scount) scount = 2'(b[0]) + 2'd1;
                ph = P_SPT;
            end
            P_SPT: begin
                if (b == 0 || b > MAX_SEC) err = itrd_pkg::ST_RANGE;
                else begin
                    bcount = 11'(b);
                    ph = P_SIZE;
                end
            end
            P_SIZE: begin
                if (known && (bcount != 11'(lspt) || b[1:0] != lcode || f_dens != ldens))
                    err = itrd_pkg::ST_GEOMETRY;
                else begin
                    if (known) f_learn = 0;
                    else begin
                        lspt = 6'(bcount); lcode = b[1:0]; ldens = f_dens;
                        lskew = '0; known = 1; f_learn = 1;
                    end
                    bcount = '0; sidx = '0; ph = P_SMAP;
                end
            end
            P_SMAP: begin
                if (f_learn && bcount < MAX_SEC) begin
                    smap[bcount] = b;
                    if (bcount == 1) lskew = {1'b0, b} - {1'b0, smap[0]};
                end
                bcount = bcount + 11'd1;
                if (bcount >= 11'(lspt)) begin
                    bcount = '0;
                    ph = f_cmap ? P_CMAP : (f_hmap ? P_HMAP : P_TYPE);
                end
            end
            P_CMAP, P_HMAP: begin
                bcount = bcount + 11'd1;
                if (bcount >= 11'(lspt)) begin
                    bcount = '0;
                    ph = (ph == P_CMAP && f_hmap) ? P_HMAP : P_TYPE;
                end
            end
            P_TYPE: begin
                if (b == 0) begin
                    if (next_sector()) begin
                        r = make_result(itrd_pkg::KIND_TRACK_END, '0, '0, '0,
                                        itrd_pkg::ST_OK);
                        got = 1;
                    end
                end else if (b == 1 || b == 2) begin
                    if (sec == 0 || sec > 8'(lspt)) err = itrd_pkg::ST_RANGE;
                    else begin
                        bcount = '0;
                        ph = (b == 1) ? P_DATA : P_FILL;
                    end
                end else err = itrd_pkg::ST_TYPE;
            end
            P_DATA: begin
                a = 32'(tbase) + 32'(sec - 8'd1) * 32'(ssz) + 32'(bcount);
                bcount = bcount + 11'd1;
                fin = 0;
                if (bcount >= ssz) fin = next_sector();
                r = make_result(fin ? itrd_pkg::KIND_TRACK_END : itrd_pkg::KIND_WRITE,
                                23'(a), b, 11'd1, itrd_pkg::ST_OK);
                got = 1;
            end
            P_FILL: begin
                a = 32'(tbase) + 32'(sec - 8'd1) * 32'(ssz);
                fin = next_sector();
                r = make_result(fin ? itrd_pkg::KIND_TRACK_END : itrd_pkg::KIND_WRITE,
                                23'(a), b, ssz, itrd_pkg::ST_OK);
                got = 1;
            end
            default: ph = P_HDR;
        endcase
        if (err == itrd_pkg::ST_OK && last) begin
            if (ph == P_HDR) err = itrd_pkg::ST_NO_TERM;
            else if (ph != P_MODE) err = itrd_pkg::ST_TRUNC;
        end
        if (err != itrd_pkg::ST_OK) begin
            sticky = 1;
            r = make_result(itrd_pkg::KIND_ERROR, '0, '0, '0, err);
            got = 1;
        end
        return got;
    endfunction

    // Send one byte; called and returns at a falling edge
    task automatic send_byte(logic [7:0] b, bit start, bit last);
        rec_result_t r;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1; s_tdata = b; s_tuser = start; s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        if (decode_byte(b, start, last, r)) expected_q.push_back(r);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_file(bit start);
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], start && i == 0, i == file_q.size() - 1);
        file_q.delete();
    endtask

    task automatic put(byte unsigned b);
        file_q.push_back(b);
    endtask

    // Track header and map; sector records are added by the caller
    task automatic put_track(byte unsigned mode, byte unsigned cyl, byte unsigned head,
            byte unsigned spt, byte unsigned size);
        put(mode); put(cyl); put(head); put(spt); put(size);
        for (int i = 0; i < spt; i++) put(8'(i + 1));
        if (head[7]) for (int i = 0; i < spt; i++) put(cyl);
        if (head[6]) for (int i = 0; i < spt; i++) put(8'(head[0]));
    endtask

    // Receiver readiness; a hold stalls it outright
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        rec_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            {got.skew, got.dens, got.sbytes, got.spt, got.sides, got.tracks, got.track,
             got.status, got.run, got.fill, got.addr} = m_tdata[90:0];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got.kind != want.kind || got.addr != want.addr || got.fill != want.fill
                        || got.run != want.run || got.status != want.status
                        || got.track != want.track || got.tracks != want.tracks
                        || got.sides != want.sides || got.spt != want.spt
                        || got.sbytes != want.sbytes || got.dens != want.dens
                        || got.skew != want.skew) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic test_header();
        put("I"); put("M"); put(8'hff);
        send_file(1);                         // final byte in header
        put(8'h00); put(itrd_pkg::HDR_TERM);
        send_file(1);                         // clean stop right after header
    endtask

    task automatic test_record_errors();
        put(itrd_pkg::HDR_TERM); put(0); put(0); put(0); put(0);
        send_file(1);                         // zero sector count
        put(itrd_pkg::HDR_TERM); put(5); put(0); put(0); put(33);
        send_file(1);                         // too many sectors
        put(itrd_pkg::HDR_TERM); put_track(5, 0, 0, 1, 0); put(3);
        send_file(1);                         // bad record type
        put(itrd_pkg::HDR_TERM); put(0); put(0); put(0); put(2); put(0); put(0); put(1);
        put(2);
        send_file(1);                         // sector number zero
        put(itrd_pkg::HDR_TERM); put_track(0, 0, 0, 2, 0); put(2); put(8'h55); put(9);
        send_file(1);                         // record type 9 after the first sector
        send_byte(8'h77, 0, 0);               // ignored after an error
    endtask

    task automatic test_tracks();
        put(itrd_pkg::HDR_TERM);
        put_track(3, 0, 8'hc1, 2, 3);         // both maps, side 1, 1024 byte sectors
        put(2); put(8'h00); put(2); put(8'hff);
        put_track(3, 2, 8'h00, 2, 3);         // cylinder skip warning
        put(2); put(8'ha5); put(0);           // last sector unavailable
        put_track(3, 1, 8'h00, 3, 3);         // geometry mismatch
        send_file(1);
    endtask

    // Well-formed files with random content, some broken on purpose
    task automatic test_random_files(int n_items);
        int stop, spt, code, ntr, t, kind_pick;
        byte unsigned mode, cyl, head;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            for (int i = $urandom_range(3); i > 0; i--) put(8'($urandom_range(8'h19)));
            put(itrd_pkg::HDR_TERM);
            spt = ($urandom_range(9) == 0) ? $urandom_range(32, 1) : $urandom_range(4, 1);
            code = $urandom_range(3);
            mode = 8'($urandom_range(5));
            ntr = $urandom_range(4, 1);
            for (t = 0; t < ntr; t++) begin
                cyl = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'(t);
                head = 8'(($urandom & 8'hc0) | $urandom_range(1) | ($urandom & 8'h3e));
                put(mode); put(cyl); put(head); put(8'(spt));
                put(8'(($urandom & 8'hfc) | code));
                for (int i = 0; i < spt; i++)
                    put(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'(i + 1));
                if (head[7]) for (int i = 0; i < spt; i++) put(8'($urandom));
                if (head[6]) for (int i = 0; i < spt; i++) put(8'($urandom));
                for (int i = 0; i < spt; i++) begin
                    kind_pick = $urandom_range(99);
                    if (kind_pick < 20) put(0);
                    else if (kind_pick < 28 && code == 0) begin
                        put(1);
                        for (int k = 0; k < 128; k++) put(8'($urandom));
                    end else if (kind_pick < 30) put(8'($urandom_range(255, 3)));
                    else begin
                        put(2); put(8'($urandom));
                    end
                end
            end
            if ($urandom_range(9) == 0)
                file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
            if ($urandom_range(9) == 0) file_q = file_q[0:$urandom_range(file_q.size() - 1)];
            send_file($urandom_range(9) != 0);
            for (int i = $urandom_range(2); i > 0; i--)
                send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // Receiver stalls long while a fill-only file keeps coming
    task automatic test_backpressure();
        hold_cycles = 300;
        put(itrd_pkg::HDR_TERM);
        for (int t = 0; t < 8; t++) begin
            put_track(0, 8'(t), 0, 4, 0);
            for (int i = 0; i < 4; i++) begin put(2); put(8'(t * 4 + i)); end
        end
        send_file(1);
    endtask

    initial begin
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; s_tuser = 1'b0;
        m_tready = 1'b0; hold_cycles = 0; send_idle = 31; recv_idle = 88;
        mismatches = 0; cycles = 0; items_sent = 0;
        clear_parser();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_header();
        test_record_errors();
        test_tracks();
        test_random_files(280);
        send_idle = 88; recv_idle = 31;
        test_random_files(280);
        send_idle = 0; recv_idle = 0;
        test_backpressure();
        test_random_files(280);

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/itrd_pkg.sv
rtl/itrd_front.sv
rtl/itrd_back.sv
rtl/imd_track_record_decoder.sv
verif/imd_track_record_decoder_test.sv
